// ===== rtl/utf8_char_tokenizer_defines.svh =====
// Assertion macros shared by the tokenizer checker.
`ifndef UTF8_CHAR_TOKENIZER_DEFINES_SVH
`define UTF8_CHAR_TOKENIZER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define U8TOK_ASSERT_IMPL(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("tokenizer check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define U8TOK_ASSERT_NEXT(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("tokenizer check failed");

`endif

// ===== rtl/u8tok_pkg.sv =====
// Package with token codes, symbol table and lookup function for the tokenizer.
`default_nettype none

package u8tok_pkg;

    localparam int BYTE_W  = 8;
    localparam int TOKEN_W = 7;
    localparam int CP_W    = 21;

    localparam logic [TOKEN_W-1:0] TOK_UNK        = 7'd1;
    localparam logic [TOKEN_W-1:0] TOK_BOS        = 7'd2;
    localparam logic [TOKEN_W-1:0] TOK_EOS        = 7'd3;
    localparam logic [TOKEN_W-1:0] TOK_PUNCT_BASE = 7'd4;
    localparam logic [TOKEN_W-1:0] TOK_UPPER_BASE = 7'd28;
    localparam logic [TOKEN_W-1:0] TOK_LOWER_BASE = 7'd54;
    localparam logic [TOKEN_W-1:0] TOK_MAX        = 7'd79;

    localparam int NUM_PUNCT = 24;

    localparam logic [CP_W-1:0] PUNCT_CP [NUM_PUNCT] = '{
        21'h3B, 21'h3A, 21'h2C, 21'h2E, 21'h21, 21'h3F,
        21'hA1, 21'hBF, 21'h2014, 21'h2026, 21'h22, 21'hAB,
        21'hBB, 21'h201C, 21'h201D, 21'h28, 21'h29, 21'h20,
        21'h2A, 21'h7E, 21'h2D, 21'h2F, 21'h5C, 21'h26
    };

    // Up to two tokens produced by one text word, in emission order.
    typedef struct packed {
        logic [1:0]         cnt;
        logic [TOKEN_W-1:0] tok0;
        logic [TOKEN_W-1:0] tok1;
    } tok_pair_t;

    function automatic logic [TOKEN_W-1:0] lookup_symbol(input logic [CP_W-1:0] cp);
        logic [TOKEN_W-1:0] id;
        id = TOK_UNK;
        for (int i = 0; i < NUM_PUNCT; i++) begin
            if (cp == PUNCT_CP[i]) begin
                id = TOKEN_W'(int'(TOK_PUNCT_BASE) + i);
            end
        end
        if (cp >= 21'h41 && cp <= 21'h5A) begin
            id = TOKEN_W'(cp[TOKEN_W-1:0] - 7'h41 + TOK_UPPER_BASE);
        end
        if (cp >= 21'h61 && cp <= 21'h7A) begin
            id = TOKEN_W'(cp[TOKEN_W-1:0] - 7'h61 + TOK_LOWER_BASE);
        end
        return id;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/u8tok_decode.sv =====
// UTF-8 decoder state and token selection for one text word.
`default_nettype none

module u8tok_decode (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire logic [u8tok_pkg::BYTE_W-1:0]  byte_in,
    output u8tok_pkg::tok_pair_t               pair
);
    import u8tok_pkg::*;

    logic            started_reg, started_next;
    logic [1:0]      pending_reg, pending_next;
    logic [CP_W-1:0] accum_reg, accum_next;

    logic [CP_W-1:0]    shifted_cp;
    logic [1:0]         body_cnt;
    logic [TOKEN_W-1:0] body0;
    logic [TOKEN_W-1:0] body1;

    assign shifted_cp = {accum_reg[CP_W-7:0], byte_in[5:0]};

    always_comb
    begin
        started_next = 1'b1;
        pending_next = pending_reg;
        accum_next   = accum_reg;
        body_cnt     = 2'd0;
        body0        = TOK_EOS;
        body1        = TOK_EOS;
        if (byte_in == '0)
        begin
            started_next = 1'b0;
            pending_next = 2'd0;
            accum_next   = '0;
            if (pending_reg != 2'd0)
            begin
                body_cnt = 2'd2;
                body0    = TOK_UNK;
            end
            else
            begin
                body_cnt = 2'd1;
            end
        end
        else if (pending_reg != 2'd0)
        begin
            pending_next = pending_reg - 2'd1;
            accum_next   = shifted_cp;
            if (pending_reg == 2'd1)
            begin
                body_cnt   = 2'd1;
                body0      = lookup_symbol(shifted_cp);
                accum_next = '0;
            end
        end
        else if (!byte_in[7])
        begin
            body_cnt = 2'd1;
            body0    = lookup_symbol({13'd0, byte_in});
        end
        else if (byte_in[7:5] == 3'b110)
        begin
            accum_next   = {16'd0, byte_in[4:0]};
            pending_next = 2'd1;
        end
        else if (byte_in[7:4] == 4'b1110)
        begin
            accum_next   = {17'd0, byte_in[3:0]};
            pending_next = 2'd2;
        end
        else
        begin
            accum_next   = {18'd0, byte_in[2:0]};
            pending_next = 2'd3;
        end
    end

    // A new text always leads with the begin token; the body then holds at most one token.
    always_comb
    begin
        if (!started_reg)
        begin
            pair.cnt  = body_cnt + 2'd1;
            pair.tok0 = TOK_BOS;
            pair.tok1 = body0;
        end
        else
        begin
            pair.cnt  = body_cnt;
            pair.tok0 = body0;
            pair.tok1 = body1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            pending_reg <= 2'd0;
            accum_reg   <= '0;
        end
        else if (step)
        begin
            started_reg <= started_next;
            pending_reg <= pending_next;
            accum_reg   <= accum_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/utf8_char_tokenizer.sv =====
// An accepted text word is registered in the input stage, then decoded into the token buffer.
// Throughput: one text word per cycle while each word gives at most one token and the token
// port accepts; a two-token word holds the input until its first token has been taken.
// The buffer drains one token per cycle while token_ready is high, which sets the peak rate.
// Reset is asynchronous and active low; it closes any open text and empties all stages.
`default_nettype none

module utf8_char_tokenizer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          text_valid,
    output logic                               text_ready,
    input  wire logic [u8tok_pkg::BYTE_W-1:0]  text_byte,
    output logic                               token_valid,
    input  wire logic                          token_ready,
    output logic [u8tok_pkg::TOKEN_W-1:0]      token_id,
    output logic                               run_last
);
    import u8tok_pkg::*;

    logic               in_vld_reg, in_vld_next;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic [1:0]         cnt_reg, cnt_next;
    logic [TOKEN_W-1:0] tok0_reg, tok0_next;
    logic [TOKEN_W-1:0] tok1_reg;

    tok_pair_t pair;
    logic      pop;
    logic      pair_free;
    logic      process;
    logic      load;

    u8tok_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (process),
        .byte_in (in_byte_reg),
        .pair    (pair)
    );

    assign token_valid = (cnt_reg != 2'd0);
    assign token_id    = tok0_reg;
    assign run_last    = (cnt_reg == 2'd1);

    assign pop        = token_valid && token_ready;
    assign pair_free  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && token_ready);
    assign process    = in_vld_reg && ((pair.cnt == 2'd0) || pair_free);
    assign load       = process && (pair.cnt != 2'd0);
    assign text_ready = !in_vld_reg || process;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (text_valid && text_ready)
        begin
            in_vld_next = 1'b1;
        end
        else if (process)
        begin
            in_vld_next = 1'b0;
        end

        cnt_next  = cnt_reg;
        tok0_next = tok0_reg;
        if (load)
        begin
            cnt_next  = pair.cnt;
            tok0_next = pair.tok0;
        end
        else if (pop)
        begin
            cnt_next  = cnt_reg - 2'd1;
            tok0_next = tok1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_valid && text_ready)
        begin
            in_byte_reg <= text_byte;
        end
        tok0_reg <= tok0_next;
        if (load)
        begin
            tok1_reg <= pair.tok1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/u8tok_checker.sv =====
// Port-level checker for the tokenizer and its bind statement.
`default_nettype none
`include "utf8_char_tokenizer_defines.svh"

module u8tok_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          token_valid,
    input wire logic                          token_ready,
    input wire logic [u8tok_pkg::TOKEN_W-1:0] token_id,
    input wire logic                          run_last
);
    import u8tok_pkg::*;

    logic token_pop;

    assign token_pop = token_valid && token_ready;

    `U8TOK_ASSERT_NEXT(a_token_hold, token_valid && !token_ready,
        token_valid && $stable(token_id) && $stable(run_last))
    `U8TOK_ASSERT_IMPL(a_token_range, token_valid,
        token_id >= TOK_UNK && token_id <= TOK_MAX)
    `U8TOK_ASSERT_IMPL(a_eos_last, token_valid && token_id == TOK_EOS, run_last)
    `U8TOK_ASSERT_NEXT(a_run_continues, token_pop && !run_last, token_valid)
    `U8TOK_ASSERT_NEXT(a_trunc_then_eos, token_pop && !run_last && token_id == TOK_UNK,
        token_valid && token_id == TOK_EOS && run_last)

endmodule

bind utf8_char_tokenizer u8tok_checker u_checker (.*);

`default_nettype wire

// ===== test/utf8_char_tokenizer_test.sv =====
// Self-checking testbench for the UTF-8 character tokenizer with a token scoreboard.
`timescale 1ns / 1ps

typedef struct packed {
    logic [u8tok_pkg::TOKEN_W-1:0] id;
    logic                          last;
} token_word_t;

class token_scoreboard;
    token_word_t                   expected_tokens[$];
    bit                            text_open;
    bit [1:0]                      pending;
    bit [u8tok_pkg::CP_W-1:0]      accum;
    int                            errors;
    int                            words_noted;
    int                            texts_closed;
    int                            tokens_checked;

    function new();
        text_open = 1'b0;
        pending = 2'd0;
        accum = '0;
        errors = 0;
        words_noted = 0;
        texts_closed = 0;
        tokens_checked = 0;
    endfunction

    function logic [u8tok_pkg::TOKEN_W-1:0] symbol_of(input bit [u8tok_pkg::CP_W-1:0] cp);
        logic [u8tok_pkg::TOKEN_W-1:0] id;
        id = u8tok_pkg::TOK_UNK;
        case (cp)
            21'h3B:   id = u8tok_pkg::TOK_PUNCT_BASE + 7'd0;
            21'h3A:   id = u8tok_pkg::TOK_PUNCT_BASE + 7'd1;
            21'h2C:   id = u8tok_pkg::TOK_PUNCT_BASE + 7'd2;
            21'h2E:   id = u8tok_pkg::TOK_PUNCT_BASE + 7'd3;
            21'h21:   id = u8tok_pkg::TOK_PUNCT_BASE + 7'd4;
            21'h3F:   id = u8tok_pkg::TOK_PUNCT_BASE + 7'd5;
            21'hA1:   id = u8tok_pkg::TOK_PUNCT_BASE + 7'd6;
            21'hBF:   id = u8tok_pkg::TOK_PUNCT_BASE + 7'd7;
            21'h2014: id = u8tok_pkg::TOK_PUNCT_BASE + 7'd8;
            21'h2026: id = u8tok_pkg::TOK_PUNCT_BASE + 7'd9;
            21'h22:   id = u8tok_pkg::TOK_PUNCT_BASE + 7'd10;
            21'hAB:   id = u8tok_pkg::TOK_PUNCT_BASE + 7'd11;
            21'hBB:   id = u8tok_pkg::TOK_PUNCT_BASE + 7'd12;
            21'h201C: id = u8tok_pkg::TOK_PUNCT_BASE + 7'd13;
            21'h201D: id = u8tok_pkg::TOK_PUNCT_BASE + 7'd14;
            21'h28:   id = u8tok_pkg::TOK_PUNCT_BASE + 7'd15;
            21'h29:   id = u8tok_pkg::TOK_PUNCT_BASE + 7'd16;
            21'h20:   id = u8tok_pkg::TOK_PUNCT_BASE + 7'd17;
            21'h2A:   id = u8tok_pkg::TOK_PUNCT_BASE + 7'd18;
            21'h7E:   id = u8tok_pkg::TOK_PUNCT_BASE + 7'd19;
            21'h2D:   id = u8tok_pkg::TOK_PUNCT_BASE + 7'd20;
            21'h2F:   id = u8tok_pkg::TOK_PUNCT_BASE + 7'd21;
            21'h5C:   id = u8tok_pkg::TOK_PUNCT_BASE + 7'd22;
            21'h26:   id = u8tok_pkg::TOK_PUNCT_BASE + 7'd23;
            default:
            begin
                if (cp >= 21'h41 && cp <= 21'h5A)
                begin
                    id = u8tok_pkg::TOK_UPPER_BASE + cp[6:0] - 7'h41;
                end
                else if (cp >= 21'h61 && cp <= 21'h7A)
                begin
                    id = u8tok_pkg::TOK_LOWER_BASE + cp[6:0] - 7'h61;
                end
            end
        endcase
        return id;
    endfunction

    function void note_word(input logic [7:0] b);
        token_word_t due[$];
        token_word_t t;
        words_noted++;
        t.last = 1'b0;
        if (!text_open)
        begin
            t.id = u8tok_pkg::TOK_BOS;
            due = {due, t};
            text_open = 1'b1;
        end
        if (b == 8'h00)
        begin
            if (pending != 2'd0)
            begin
                t.id = u8tok_pkg::TOK_UNK;
                due = {due, t};
            end
            t.id = u8tok_pkg::TOK_EOS;
            due = {due, t};
            text_open = 1'b0;
            pending = 2'd0;
            accum = '0;
            texts_closed++;
        end
        else if (pending != 2'd0)
        begin
            accum = {accum[14:0], b[5:0]};
            pending = pending - 2'd1;
            if (pending == 2'd0)
            begin
                t.id = symbol_of(accum);
                due = {due, t};
                accum = '0;
            end
        end
        else if (!b[7])
        begin
            t.id = symbol_of({13'd0, b});
            due = {due, t};
        end
        else if (b[7:5] == 3'b110)
        begin
            accum = {16'd0, b[4:0]};
            pending = 2'd1;
        end
        else if (b[7:4] == 4'b1110)
        begin
            accum = {17'd0, b[3:0]};
            pending = 2'd2;
        end
        else
        begin
            accum = {18'd0, b[2:0]};
            pending = 2'd3;
        end
        if (due.size() > 0)
        begin
            due[due.size()-1].last = 1'b1;
        end
        foreach (due[i])
        begin
            expected_tokens = {expected_tokens, due[i]};
        end
    endfunction

    task report(input string msg);
        errors++;
        if (errors <= 40)
        begin
            $display("MISMATCH: %s", msg);
        end
    endtask

    task check_token(input logic [u8tok_pkg::TOKEN_W-1:0] id, input logic last);
        token_word_t want;
        tokens_checked++;
        if (expected_tokens.size() == 0)
        begin
            report($sformatf("token %0d (last %0b) with nothing expected", id, last));
        end
        else
        begin
            want = expected_tokens.pop_front();
            if (id !== want.id)
            begin
                report($sformatf("token %0d: id %0d, expected %0d",
                                 tokens_checked, id, want.id));
            end
            if (last !== want.last)
            begin
                report($sformatf("token %0d: run_last %0b, expected %0b",
                                 tokens_checked, last, want.last));
            end
        end
    endtask
endclass

module utf8_char_tokenizer_test;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_WORDS  = 750;
    localparam int CALM_WORDS    = 80;
    localparam int DRAIN_CYCLES  = 16;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            text_valid = 1'b0;
    logic                            text_ready;
    logic [u8tok_pkg::BYTE_W-1:0]    text_byte = '0;
    logic                            token_valid;
    logic                            token_ready = 1'b0;
    logic [u8tok_pkg::TOKEN_W-1:0]   token_id;
    logic                            run_last;

    token_scoreboard sb = new();

    logic [7:0]  byte_plan[$];
    bit          calm = 1'b0;
    int          stall_left = 0;

    logic [7:0] directed_bytes [23] = '{
        8'h00, 8'h41, 8'h7A, 8'h7E, 8'h7F, 8'hC2, 8'hA1, 8'hE2,
        8'h80, 8'h94, 8'h80, 8'h41, 8'h41, 8'h41, 8'hC1, 8'h81,
        8'hE2, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00
    };

    logic [20:0] punct_points [24] = '{
        21'h3B, 21'h3A, 21'h2C, 21'h2E, 21'h21, 21'h3F,
        21'hA1, 21'hBF, 21'h2014, 21'h2026, 21'h22, 21'hAB,
        21'hBB, 21'h201C, 21'h201D, 21'h28, 21'h29, 21'h20,
        21'h2A, 21'h7E, 21'h2D, 21'h2F, 21'h5C, 21'h26
    };

    utf8_char_tokenizer DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_ready  (text_ready),
        .text_byte   (text_byte),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token_id    (token_id),
        .run_last    (run_last)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (text_valid && text_ready)
            begin
                sb.note_word(text_byte);
            end
            if (token_valid && token_ready)
            begin
                sb.check_token(token_id, run_last);
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            token_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 15) - 1;
            token_ready <= 1'b0;
        end
        else
        begin
            token_ready <= 1'b1;
        end
    end

    task automatic plan_byte(input logic [7:0] b);
        byte_plan = {byte_plan, b};
    endtask

    task automatic add_codepoint(input logic [20:0] cp, input int min_len);
        int len;
        if (cp < 21'h80)
            len = 1;
        else if (cp < 21'h800)
            len = 2;
        else if (cp < 21'h10000)
            len = 3;
        else
            len = 4;
        if (min_len > len)
            len = min_len;
        case (len)
            1:
            begin
                plan_byte(cp[7:0]);
            end
            2:
            begin
                plan_byte({3'b110, cp[10:6]});
                plan_byte({2'b10, cp[5:0]});
            end
            3:
            begin
                plan_byte({4'b1110, cp[15:12]});
                plan_byte({2'b10, cp[11:6]});
                plan_byte({2'b10, cp[5:0]});
            end
            default:
            begin
                plan_byte({5'b11110, cp[20:18]});
                plan_byte({2'b10, cp[17:12]});
                plan_byte({2'b10, cp[11:6]});
                plan_byte({2'b10, cp[5:0]});
            end
        endcase
    endtask

    task automatic add_random_char();
        int          pick;
        logic [20:0] cp;
        pick = $urandom_range(0, 99);
        if (pick < 18)
            cp = 21'h41 + 21'($urandom_range(0, 25));
        else if (pick < 35)
            cp = 21'h61 + 21'($urandom_range(0, 25));
        else if (pick < 60)
            cp = punct_points[$urandom_range(0, 23)];
        else if (pick < 75)
            cp = 21'($urandom_range(1, 127));
        else if (pick < 85)
            cp = 21'($urandom_range(21'h80, 21'h7FF));
        else if (pick < 93)
            cp = 21'($urandom_range(21'h800, 21'hFFFF));
        else
            cp = 21'($urandom_range(21'h10000, 21'h1FFFFF));
        if ($urandom_range(0, 9) == 0)
            add_codepoint(cp, $urandom_range(1, 4));
        else
            add_codepoint(cp, 1);
    endtask

    task automatic add_random_text();
        int kind;
        int count;
        kind = $urandom_range(0, 9);
        count = $urandom_range(0, 10);
        if (kind == 0)
        begin
            repeat (count + 1)
            begin
                plan_byte(8'($urandom_range(1, 255)));
            end
        end
        else
        begin
            repeat (count)
            begin
                add_random_char();
            end
            if (kind == 1)
            begin
                plan_byte(8'($urandom_range(8'hC0, 8'hFF)));
                if ($urandom_range(0, 1) == 1)
                    plan_byte(8'($urandom_range(8'h80, 8'hBF)));
            end
        end
        plan_byte(8'h00);
    endtask

    task automatic send_word(input logic [7:0] b);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            text_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        text_valid <= 1'b1;
        text_byte <= b;
        @(posedge clk);
        while (!text_ready) @(posedge clk);
    endtask

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timed out with %0d tokens outstanding.", sb.expected_tokens.size());
        $display("utf8_char_tokenizer regression: fail");
        $finish;
    end

    initial
    begin
        foreach (directed_bytes[i])
        begin
            plan_byte(directed_bytes[i]);
        end
        while (byte_plan.size() < $size(directed_bytes) + RANDOM_WORDS)
        begin
            add_random_text();
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (byte_plan[i])
        begin
            calm = (i + CALM_WORDS >= byte_plan.size());
            send_word(byte_plan[i]);
        end
        text_valid <= 1'b0;

        while (sb.expected_tokens.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d text words over %0d texts, with directed edge cases and random text.",
                 sb.words_noted, sb.texts_closed);
        $display("Checked %0d tokens; %0d mismatches.", sb.tokens_checked, sb.errors);
        if (sb.errors == 0)
        begin
            $display("utf8_char_tokenizer regression: pass");
        end
        else
        begin
            $display("utf8_char_tokenizer regression: fail");
        end
        $finish;
    end

endmodule
